### rtl/ebsfd_pkg.sv
// shared types, constants and byte decode function for the status frame decoder
package ebsfd_pkg;

  localparam int unsigned SPEED_RECIP = 61681;  // ceil(2^20 / 17)
  localparam int unsigned SPEED_SHIFT = 20;
  localparam logic [7:0] SPEED_MAX = 8'd199;
  localparam logic [7:0] WRAP_ADD = 8'hfe;
  localparam logic [28:0] TIME_SCALE = 29'd20;
  localparam logic [7:0] PARK_MASK = 8'h0b;
  localparam int unsigned DIV_STEPS = 29;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // one incoming frame
  typedef struct packed {
    logic [7:0] status_byte_two;
    logic [7:0] status_byte_three;
    logic [7:0] status_byte_four;
    logic [7:0] status_byte_five;
    logic [7:0] speed_high_byte;
    logic [7:0] speed_low_byte;
    logic [7:0] offset_byte;
  } frame_t;

  // one decoded result
  typedef struct packed {
    logic [11:0] event_mask;
    logic [2:0]  gear_number;
    logic [7:0]  speed_value;
    logic [28:0] time_limit;
    logic        parking_active;
    logic        ecu_alert;
    logic        restart_timer;
    logic        side_symbol;
  } result_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic mult;
    logic setup;
    logic step;
    logic out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
    logic out_free;
  } sts_t;

  // offset removal with wrap correction
  function automatic logic [7:0] decode_byte(input logic [7:0] raw, input logic [7:0] off,
                                             input logic subtract);
    logic [7:0] v;
    v = subtract ? 8'(raw - off) : raw;
    if (v < off) v = 8'(v + WRAP_ADD);
    return v;
  endfunction

endpackage

### rtl/ebike_status_frame_decoder_unit.sv
// top level of the status frame decoder
//
// channel   direction  handshake                  payload
// frame     in         frame_valid / frame_stall  frame_t, one controller frame
// result    out        result_valid / result_stall result_t, one decoded status
// cfg       in         cfg_valid / cfg_ready      24-bit distance divisor
//
// a frame passes through the accepting cycle, a multiply, a setup, 29 divider steps,
// a done check and a load before the next frame can be accepted.
// rst is synchronous; it clears the divisor, the side stand latch, the step counter, result_valid and control.
// a result waits in its output register while the next frame is accepted;
// if that result is still stalled when the next one is done, the block holds.
module ebike_status_frame_decoder_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               frame_valid,
  output logic               frame_stall,
  input  ebsfd_pkg::frame_t  frame,
  output logic               result_valid,
  input  logic               result_stall,
  output ebsfd_pkg::result_t result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [23:0]        cfg_data
);

  ebsfd_pkg::cmd_t cmd;
  ebsfd_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  // controller
  ebsfd_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  // datapath
  ebsfd_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .frame        (frame),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .result_stall (result_stall),
    .result_valid (result_valid),
    .result       (result),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

### rtl/ebsfd_ctrl.sv
// sequencing state machine for the status frame decoder
module ebsfd_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            frame_valid,
  output logic            frame_stall,
  input  ebsfd_pkg::sts_t sts,
  output ebsfd_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MULT  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign frame_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (frame_valid) begin
          cmd.capture = 1'b1;
          state_next = S_MULT;
        end
      end
      S_MULT: begin
        cmd.mult = 1'b1;
        state_next = S_SETUP;
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_next = S_WAIT;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_WAIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/ebsfd_dpath.sv
// frame registers, speed scaling, time limit divider and result register
module ebsfd_dpath (
  input  logic               clk,
  input  logic               rst,
  input  ebsfd_pkg::frame_t  frame,
  input  logic               cfg_valid,
  input  logic [23:0]        cfg_data,
  input  logic               result_stall,
  output logic               result_valid,
  output ebsfd_pkg::result_t result,
  input  ebsfd_pkg::cmd_t    cmd,
  output ebsfd_pkg::sts_t    sts
);

  ebsfd_pkg::frame_t frame_reg;
  logic [23:0] distance_divisor;
  logic        side_latch;
  logic [31:0] prod;
  logic [7:0]  speed;
  logic        restart;
  logic [7:0]  rem;
  logic [28:0] quo;
  logic [ebsfd_pkg::DIV_CNT_W-1:0] cnt;

  logic [7:0]  b2, b3, b4, b5, b7, b8, off;
  logic [15:0] count;
  logic [11:0] speed_raw;
  logic [28:0] full;
  logic [8:0]  trial;
  logic        ge;
  logic [2:0]  gear;
  logic        park;
  logic        side_next;
  logic [11:0] ev;

  // decoded frame bytes
  always_comb begin
    off = frame_reg.offset_byte;
    b2 = frame_reg.status_byte_two;
    b3 = ebsfd_pkg::decode_byte(frame_reg.status_byte_three, off, 1'b0);
    b4 = ebsfd_pkg::decode_byte(frame_reg.status_byte_four, off, 1'b1);
    b5 = ebsfd_pkg::decode_byte(frame_reg.status_byte_five, off, 1'b1);
    b7 = ebsfd_pkg::decode_byte(frame_reg.speed_high_byte, off, 1'b1);
    b8 = ebsfd_pkg::decode_byte(frame_reg.speed_low_byte, off, 1'b1);
    count = {b7, b8};
  end

  // count / 17 from the reciprocal product
  assign speed_raw = prod[ebsfd_pkg::SPEED_SHIFT +: 12];
  assign full = 29'(distance_divisor) * ebsfd_pkg::TIME_SCALE;

  // one restoring divide step
  always_comb begin
    trial = {rem, quo[28]};
    ge = (trial >= {1'b0, speed});
  end

  // config register and side stand latch
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_divisor <= '0;
      side_latch <= 1'b0;
    end else begin
      if (cfg_valid) distance_divisor <= cfg_data;
      if (cmd.out_load) side_latch <= side_next;
    end
  end

  // frame capture, product, divider
  always_ff @(posedge clk) begin
    if (cmd.capture) frame_reg <= frame;
    if (cmd.mult) prod <= 32'(count) * 32'(ebsfd_pkg::SPEED_RECIP);
    if (cmd.setup) begin
      restart <= (speed_raw < 12'd2);
      if (speed_raw < 12'd2) begin
        speed <= '0;
      end else if (speed_raw > 12'(ebsfd_pkg::SPEED_MAX)) begin
        speed <= ebsfd_pkg::SPEED_MAX;
      end else begin
        speed <= speed_raw[7:0];
      end
      rem <= '0;
      quo <= full;
    end else if (cmd.step) begin
      rem <= ge ? 8'(trial - {1'b0, speed}) : trial[7:0];
      quo <= {quo[27:0], ge};
    end
  end

  // step counter, reset so the done status is defined
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.setup) begin
      cnt <= ebsfd_pkg::DIV_CNT_W'(ebsfd_pkg::DIV_STEPS);
    end else if (cmd.step) begin
      cnt <= cnt - 1'b1;
    end
  end

  // flag decode
  always_comb begin
    park = b3[7] | (|(b2 & ebsfd_pkg::PARK_MASK));
    gear = b4[7] ? 3'd4 : {1'b0, b4[1:0]};
    ev = '0;
    ev[0] = park;
    ev[1] = !park;
    if (b5[2]) ev[2] = 1'b1;
    else if (b3[2]) ev[3] = 1'b1;
    else if (b5[0]) ev[4] = 1'b1;
    else if (gear != 3'd0) ev[5] = 1'b1;
    ev[6] = b5[1] | b4[5];
    ev[7] = b3[5];
    ev[8] = b3[6] | b3[0];
    ev[9] = b5[6] | b5[1] | b4[5];
    ev[10] = b3[3];
    ev[11] = b3[4];
    side_next = side_latch | b5[6];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.event_mask <= ev;
      result.gear_number <= gear;
      result.speed_value <= speed;
      result.time_limit <= restart ? full : quo;
      result.parking_active <= park;
      result.ecu_alert <= b3[4] | b3[3];
      result.restart_timer <= restart;
      result.side_symbol <= side_next;
    end
  end

  assign sts.div_done = (cnt == '0);
  assign sts.out_free = !result_valid || !result_stall;

endmodule
